/* rtl/core/fsa_pkg.sv */
// Shared types, constants and decode functions for the flow statistics accumulator.
`default_nettype none

package fsa_pkg;

    localparam int COUNT_WIDTH_DEF = 64;
    localparam int NUM_CLASSES     = 4;
    localparam int CLASS_W         = $clog2(NUM_CLASSES);
    localparam int ROW_COUNTERS    = 3;
    localparam int STAT_W          = 64;

    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [7:0]  PROTO_ICMP  = 8'd1;
    localparam logic [31:0] SEQ_MODULUS = 32'hffff_ffff;

    // Statistic indexes
    localparam logic [4:0] STAT_TOT_FLOWS   = 5'd0;
    localparam logic [4:0] STAT_TOT_BYTES   = 5'd1;
    localparam logic [4:0] STAT_TOT_PACKETS = 5'd2;
    localparam logic [4:0] STAT_CLS_FIRST   = 5'd3;
    localparam logic [4:0] STAT_CLS_LAST    = 5'd14;
    localparam logic [4:0] STAT_EARLY_SEC   = 5'd15;
    localparam logic [4:0] STAT_EARLY_MSEC  = 5'd16;
    localparam logic [4:0] STAT_LATE_SEC    = 5'd17;
    localparam logic [4:0] STAT_LATE_MSEC   = 5'd18;
    localparam logic [4:0] STAT_SEQ_FAIL    = 5'd19;
    localparam logic [4:0] STAT_EXP_SEQ     = 5'd20;

    // Class rows in the counter memory, in statistic index order
    localparam logic [CLASS_W-1:0] CLS_TCP   = CLASS_W'(0);
    localparam logic [CLASS_W-1:0] CLS_UDP   = CLASS_W'(1);
    localparam logic [CLASS_W-1:0] CLS_ICMP  = CLASS_W'(2);
    localparam logic [CLASS_W-1:0] CLS_OTHER = CLASS_W'(3);

    typedef enum logic [1:0] {
        OP_FLOW = 2'd0,
        OP_SEQ  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  protocol;
        logic [63:0] flow_bytes;
        logic [63:0] flow_packets;
        logic [31:0] start_sec;
        logic [9:0]  start_msec;
        logic [31:0] end_sec;
        logic [9:0]  end_msec;
        logic [31:0] seq_number;
        logic [31:0] msg_flow_count;
        logic [4:0]  stat_index;
    } req_item_t;

    typedef struct packed {
        logic [63:0] stat_value;
        logic        seq_mismatch;
    } rsp_item_t;

    typedef struct packed {
        logic               hit;
        logic [CLASS_W-1:0] row;
        logic [1:0]         col;
    } slot_t;

    function automatic logic [CLASS_W-1:0] proto_class(input logic [7:0] proto);
        logic [CLASS_W-1:0] cls;
        unique case (proto)
            PROTO_TCP:  cls = CLS_TCP;
            PROTO_UDP:  cls = CLS_UDP;
            PROTO_ICMP: cls = CLS_ICMP;
            default:    cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

    // Map a per-class statistic index to its memory row and column
    function automatic slot_t stat_slot(input logic [4:0] idx);
        slot_t      s;
        logic [4:0] off;
        off   = idx - STAT_CLS_FIRST;
        s.hit = (idx >= STAT_CLS_FIRST) && (idx <= STAT_CLS_LAST);
        priority if (off < 5'd3)
        begin
            s.row = CLS_TCP;
            s.col = off[1:0];
        end
        else if (off < 5'd6)
        begin
            s.row = CLS_UDP;
            s.col = 2'(off - 5'd3);
        end
        else if (off < 5'd9)
        begin
            s.row = CLS_ICMP;
            s.col = 2'(off - 5'd6);
        end
        else
        begin
            s.row = CLS_OTHER;
            s.col = 2'(off - 5'd9);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/flow_stats_accumulator_unit.sv */
// Pipeline: an accepted request is held in the stage 1 register and its response in the output
//   register; a stalled response holds it.
// Throughput: one transaction per cycle while the response is taken; the class counter RAM
//   is read in the accept cycle and written back when the transaction leaves stage 1, with a
//   forwarding register for back-to-back hits on the same protocol class.
// Reset: rst_n (async, active low) clears totals, latest times, sequence state and the per-row valid
//   bits of the class RAM, sets earliest times to all ones; no clearing pass, the block is ready right after reset.
`default_nettype none

module flow_stats_accumulator_unit #(
    parameter int COUNT_WIDTH = fsa_pkg::COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  fsa_pkg::req_item_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output fsa_pkg::rsp_item_t rsp
);

    import fsa_pkg::*;

    localparam int ROW_W = ROW_COUNTERS * COUNT_WIDTH;

    typedef logic [ROW_COUNTERS-1:0][COUNT_WIDTH-1:0] row_t;

    // Stage 0: issue the class RAM read
    logic               req_accept;
    logic [CLASS_W-1:0] rd_row;
    slot_t              req_slot;

    // Stage 1 registers
    logic               s1_valid_reg;
    req_item_t          s1_item_reg;
    logic               s1_adv;

    // Class RAM and its bookkeeping
    logic [ROW_W-1:0]       ram_rdata;
    logic                   ram_we;
    logic [NUM_CLASSES-1:0] cls_valid_reg;
    logic                   fwd_valid_reg;
    logic [CLASS_W-1:0]     fwd_row_reg;
    row_t                   fwd_data_reg;

    // Scalar state
    row_t        tot_reg;
    logic [31:0] early_sec_reg;
    logic [15:0] early_msec_reg;
    logic [31:0] late_sec_reg;
    logic [15:0] late_msec_reg;
    logic [31:0] seq_fail_reg;
    logic [31:0] exp_seq_reg;

    logic [31:0] early_sec_next;
    logic [15:0] early_msec_next;
    logic [31:0] exp_seq_next;
    row_t        tot_next;
    row_t        row_next;

    // Stage 1 datapath
    logic [CLASS_W-1:0] s1_cls;
    slot_t              s1_slot;
    logic [CLASS_W-1:0] s1_row;
    row_t               row_val;
    logic               mismatch;
    logic [31:0]        seq_base;
    logic [31:0]        seq_sum;
    logic [63:0]        read_val;
    logic [15:0]        smsec_ext;

    // Output register
    logic      rsp_valid_reg;
    rsp_item_t rsp_reg;
    rsp_item_t rsp_next;

    assign s1_adv     = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = !s1_valid_reg || s1_adv;
    assign req_accept = req_valid && req_ready;

    assign req_slot = stat_slot(req.stat_index);
    assign rd_row   = (req.op == OP_READ) ? req_slot.row : proto_class(req.protocol);

    fsa_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_CLASSES)
    ) u_cls_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_row),
        .wdata (row_next),
        .re    (req_accept),
        .raddr (rd_row),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_cls  = proto_class(s1_item_reg.protocol);
        s1_slot = stat_slot(s1_item_reg.stat_index);
        s1_row  = (s1_item_reg.op == OP_READ) ? s1_slot.row : s1_cls;

        // Latest write to this row wins over the RAM output
        if (fwd_valid_reg && (fwd_row_reg == s1_row))
        begin
            row_val = fwd_data_reg;
        end
        else if (cls_valid_reg[s1_row])
        begin
            row_val = row_t'(ram_rdata);
        end
        else
        begin
            row_val = '0;
        end

        row_next[0] = row_val[0] + COUNT_WIDTH'(1);
        row_next[1] = row_val[1] + s1_item_reg.flow_bytes[COUNT_WIDTH-1:0];
        row_next[2] = row_val[2] + s1_item_reg.flow_packets[COUNT_WIDTH-1:0];

        tot_next[0] = tot_reg[0] + COUNT_WIDTH'(1);
        tot_next[1] = tot_reg[1] + s1_item_reg.flow_bytes[COUNT_WIDTH-1:0];
        tot_next[2] = tot_reg[2] + s1_item_reg.flow_packets[COUNT_WIDTH-1:0];

        ram_we = s1_adv && (s1_item_reg.op == OP_FLOW);

        // Earliest first-seen time, milliseconds break a tie on seconds
        smsec_ext       = {6'd0, s1_item_reg.start_msec};
        early_sec_next  = early_sec_reg;
        early_msec_next = early_msec_reg;
        if (early_sec_reg > s1_item_reg.start_sec)
        begin
            early_sec_next  = s1_item_reg.start_sec;
            early_msec_next = smsec_ext;
        end
        else if ((early_sec_reg == s1_item_reg.start_sec) && (early_msec_reg > smsec_ext))
        begin
            early_msec_next = smsec_ext;
        end

        // Resync on mismatch, then advance modulo 2^32-1
        mismatch     = (s1_item_reg.seq_number != exp_seq_reg);
        seq_base     = mismatch ? s1_item_reg.seq_number : exp_seq_reg;
        seq_sum      = seq_base + s1_item_reg.msg_flow_count;
        exp_seq_next = (seq_sum == SEQ_MODULUS) ? 32'd0 : seq_sum;

        if (s1_slot.hit)
        begin
            read_val = STAT_W'(row_val[s1_slot.col]);
        end
        else
        begin
            unique case (s1_item_reg.stat_index)
                STAT_TOT_FLOWS:   read_val = STAT_W'(tot_reg[0]);
                STAT_TOT_BYTES:   read_val = STAT_W'(tot_reg[1]);
                STAT_TOT_PACKETS: read_val = STAT_W'(tot_reg[2]);
                STAT_EARLY_SEC:   read_val = STAT_W'(early_sec_reg);
                STAT_EARLY_MSEC:  read_val = STAT_W'(early_msec_reg);
                STAT_LATE_SEC:    read_val = STAT_W'(late_sec_reg);
                STAT_LATE_MSEC:   read_val = STAT_W'(late_msec_reg);
                STAT_SEQ_FAIL:    read_val = STAT_W'(seq_fail_reg);
                STAT_EXP_SEQ:     read_val = STAT_W'(exp_seq_reg);
                default:          read_val = '0;
            endcase
        end

        rsp_next.stat_value   = (s1_item_reg.op == OP_READ) ? read_val : '0;
        rsp_next.seq_mismatch = (s1_item_reg.op == OP_SEQ) && mismatch;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            cls_valid_reg  <= '0;
            fwd_valid_reg  <= 1'b0;
            fwd_row_reg    <= '0;
            tot_reg        <= '0;
            early_sec_reg  <= '1;
            early_msec_reg <= '1;
            late_sec_reg   <= '0;
            late_msec_reg  <= '0;
            seq_fail_reg   <= '0;
            exp_seq_reg    <= '0;
        end
        else
        begin
            if (req_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (ram_we)
            begin
                cls_valid_reg[s1_row] <= 1'b1;
                fwd_valid_reg         <= 1'b1;
                fwd_row_reg           <= s1_row;
                tot_reg               <= tot_next;
                early_sec_reg         <= early_sec_next;
                early_msec_reg        <= early_msec_next;
                late_sec_reg          <= s1_item_reg.end_sec;
                late_msec_reg         <= {6'd0, s1_item_reg.end_msec};
            end

            if (s1_adv && (s1_item_reg.op == OP_SEQ))
            begin
                exp_seq_reg <= exp_seq_next;
                if (mismatch)
                begin
                    seq_fail_reg <= seq_fail_reg + 32'd1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_item_reg <= req;
        end
        if (ram_we)
        begin
            fwd_data_reg <= row_next;
        end
        if (s1_adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* rtl/core/fsa_checker.sv */
// Port-level checker for the flow statistics accumulator, bound to the top level.
`default_nettype none

module fsa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input fsa_pkg::req_item_t req,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input fsa_pkg::rsp_item_t rsp
);

    import fsa_pkg::*;

    logic [1:0] pending_reg;
    logic       req_fire;
    logic       rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // Track transactions in flight: accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (req_fire && !rsp_fire)
        begin
            pending_reg <= pending_reg + 2'd1;
        end
        else if (rsp_fire && !req_fire)
        begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed or dropped");

    // No response without a transaction in flight
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("response without a pending request");

    // At most two transactions in flight
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two transactions in flight");

    // A sequence mismatch never carries a statistic value
    a_mismatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.seq_mismatch |-> rsp.stat_value == 64'd0)
        else $error("mismatch response with nonzero value");

    // An empty pipeline always takes a request
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd0 |-> req_ready)
        else $error("not ready while empty");

endmodule

bind flow_stats_accumulator_unit fsa_checker u_fsa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
